// File: sv/nearest_neighbor_image_resize_assert.svh
// Assertion macros shared by the scaler modules.
`ifndef NEAREST_NEIGHBOR_IMAGE_RESIZE_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_RESIZE_ASSERT_SVH

// consequent checked in the same cycle
`define NNIR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked in the next cycle
`define NNIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/nnir_pkg.sv
// Shared types, constants and helper functions of the image scaler.
package nnir_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int PIXEL_BITS  = 32;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int SIZE_W      = 9;
    localparam int ACC_W       = 25;
    localparam int FRAC_W      = 16;
    localparam int PICK_W      = ACC_W + 1 - FRAC_W;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 5;

    localparam logic [ACC_W-1:0]  HALF_Q16  = ACC_W'(32'h8000);
    localparam logic [ACC_W-1:0]  ONE_Q16   = ACC_W'(32'h10000);
    localparam logic [SIZE_W-1:0] SIZE_ONE  = SIZE_W'(1);

    // register indexes (word address bits [4:2])
    localparam logic [2:0] REG_SRC_W  = 3'd0;
    localparam logic [2:0] REG_SRC_H  = 3'd1;
    localparam logic [2:0] REG_DST_W  = 3'd2;
    localparam logic [2:0] REG_DST_H  = 3'd3;
    localparam logic [2:0] REG_STEP_X = 3'd4;
    localparam logic [2:0] REG_STEP_Y = 3'd5;

    // input word function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] src_w;
        logic [SIZE_W-1:0] src_h;
        logic [SIZE_W-1:0] dst_w;
        logic [SIZE_W-1:0] dst_h;
        logic [ACC_W-1:0]  step_x;
        logic [ACC_W-1:0]  step_y;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic req;
        logic mul;
        logic rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

    // zero acts as one, oversize acts as the maximum
    function automatic logic [SIZE_W-1:0] fit(input logic [SIZE_W-1:0] v, input int hi);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_ONE;
        end else if (int'(v) > hi) begin
            r = SIZE_W'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    // round to nearest, clamp to last index
    function automatic logic [PICK_W-1:0] pick(input logic [ACC_W-1:0] acc,
                                               input logic [SIZE_W-1:0] size);
        logic [ACC_W:0]    s;
        logic [PICK_W-1:0] p;
        s = {1'b0, acc} + {1'b0, HALF_Q16};
        p = s[ACC_W:FRAC_W];
        if (int'(p) >= int'(size)) begin
            p = PICK_W'(size - SIZE_ONE);
        end
        return p;
    endfunction

endpackage

// File: sv/nnir_regs.sv
// APB register file holding the scaler sizes and step ratios.
module nnir_regs import nnir_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w  <= SIZE_ONE;
            r_cfg.src_h  <= SIZE_ONE;
            r_cfg.dst_w  <= SIZE_ONE;
            r_cfg.dst_h  <= SIZE_ONE;
            r_cfg.step_x <= ONE_Q16;
            r_cfg.step_y <= ONE_Q16;
        end else if (wr_en) begin
            case (idx)
                REG_SRC_W:  r_cfg.src_w  <= pwdata[SIZE_W-1:0];
                REG_SRC_H:  r_cfg.src_h  <= pwdata[SIZE_W-1:0];
                REG_DST_W:  r_cfg.dst_w  <= pwdata[SIZE_W-1:0];
                REG_DST_H:  r_cfg.dst_h  <= pwdata[SIZE_W-1:0];
                REG_STEP_X: r_cfg.step_x <= pwdata[ACC_W-1:0];
                REG_STEP_Y: r_cfg.step_y <= pwdata[ACC_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SRC_W:  prdata = DATA_W'(r_cfg.src_w);
            REG_SRC_H:  prdata = DATA_W'(r_cfg.src_h);
            REG_DST_W:  prdata = DATA_W'(r_cfg.dst_w);
            REG_DST_H:  prdata = DATA_W'(r_cfg.dst_h);
            REG_STEP_X: prdata = DATA_W'(r_cfg.step_x);
            REG_STEP_Y: prdata = DATA_W'(r_cfg.step_y);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/nnir_ctrl.sv
// Sequencer: takes input words and steps a request through multiply, read and output.
module nnir_ctrl import nnir_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_func,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

`include "nearest_neighbor_image_resize_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       take;

    assign o_in_ready     = (r_state == S_IDLE);
    assign take           = i_in_valid && o_in_ready;
    assign o_cmd.load     = take && (i_func == FUNC_LOAD);
    assign o_cmd.req      = take && (i_func == FUNC_REQ);
    assign o_cmd.mul      = (r_state == S_MUL);
    assign o_cmd.rd       = (r_state == S_RD);
    // output register free, or being emptied this cycle
    assign o_cmd.out_load = (r_state == S_OUT) && (!i_sts.out_full || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (o_cmd.req) n_state = S_MUL;
            S_MUL:   n_state = S_RD;
            S_RD:    n_state = S_OUT;
            S_OUT:   if (o_cmd.out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `NNIR_ASSERT_NEXT(a_req_to_mul, o_cmd.req, r_state == S_MUL)
    `NNIR_ASSERT_NEXT(a_rd_to_out, r_state == S_RD, r_state == S_OUT)
    `NNIR_ASSERT_NEXT(a_out_waits, r_state == S_OUT && !o_cmd.out_load, r_state == S_OUT)

endmodule

// File: sv/nnir_dp.sv
// Datapath: frame store, load address, accumulators, address multiply and output register.
module nnir_dp import nnir_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  t_cmd            i_cmd,
    input  logic            i_out_ready,
    input  logic [31:0]     i_pixel_in,
    output t_sts            o_sts,
    output logic            o_out_valid,
    output logic [31:0]     o_pixel_out,
    output logic            o_end_of_row,
    output logic            o_end_of_frame
);

`include "nearest_neighbor_image_resize_assert.svh"

    logic [PIXEL_BITS-1:0] r_mem [STORE_DEPTH];

    logic [ADDR_W-1:0]     r_load_addr;
    logic [ACC_W-1:0]      r_xacc;
    logic [ACC_W-1:0]      r_yacc;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_px;
    logic [ROW_W-1:0]      r_py;
    logic                  r_eor;
    logic                  r_eof;
    logic [ADDR_W-1:0]     r_rd_addr;
    logic [PIXEL_BITS-1:0] r_rd_data;
    logic [PIXEL_BITS-1:0] r_pix_out;
    logic                  r_eor_out;
    logic                  r_eof_out;
    logic                  r_out_valid;

    logic [SIZE_W-1:0]     sw;
    logic [SIZE_W-1:0]     sh;
    logic [SIZE_W-1:0]     dw;
    logic [SIZE_W-1:0]     dh;
    logic [2*SIZE_W-1:0]   frame;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W:0]       addr_inc;
    logic [ADDR_W-1:0]     n_load_addr;
    logic                  eor_now;
    logic                  eof_now;
    logic [ROW_W+SIZE_W-1:0] row_base;

    assign sw    = fit(i_cfg.src_w, MAX_WIDTH);
    assign sh    = fit(i_cfg.src_h, MAX_HEIGHT);
    assign dw    = fit(i_cfg.dst_w, MAX_WIDTH);
    assign dh    = fit(i_cfg.dst_h, MAX_HEIGHT);
    assign frame = (2*SIZE_W)'(sw) * (2*SIZE_W)'(sh);

    // stray address past the frame restarts at zero
    assign wr_addr     = ((2*SIZE_W)'(r_load_addr) < frame) ? r_load_addr : '0;
    assign addr_inc    = {1'b0, wr_addr} + (ADDR_W+1)'(1);
    assign n_load_addr = ((2*SIZE_W)'(addr_inc) >= frame) ? '0 : addr_inc[ADDR_W-1:0];

    assign eor_now  = (int'(r_col) + 1) >= int'(dw);
    assign eof_now  = eor_now && ((int'(r_row) + 1) >= int'(dh));
    assign row_base = (ROW_W+SIZE_W)'(r_py) * (ROW_W+SIZE_W)'(sw);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[wr_addr] <= i_pixel_in[PIXEL_BITS-1:0];
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_addr <= '0;
            r_xacc      <= '0;
            r_yacc      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_load_addr <= n_load_addr;
            end
            if (i_cmd.req) begin
                if (eor_now) begin
                    r_col  <= '0;
                    r_xacc <= '0;
                    if (eof_now) begin
                        r_row  <= '0;
                        r_yacc <= '0;
                    end else begin
                        r_row  <= r_row + ROW_W'(1);
                        r_yacc <= acc_add(r_yacc, i_cfg.step_y);
                    end
                end else begin
                    r_col  <= r_col + COL_W'(1);
                    r_xacc <= acc_add(r_xacc, i_cfg.step_x);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.req) begin
            r_px  <= COL_W'(pick(r_xacc, sw));
            r_py  <= ROW_W'(pick(r_yacc, sh));
            r_eor <= eor_now;
            r_eof <= eof_now;
        end
        if (i_cmd.mul) begin
            r_rd_addr <= ADDR_W'(row_base + (ROW_W+SIZE_W)'(r_px));
        end
        if (i_cmd.out_load) begin
            r_pix_out <= r_rd_data;
            r_eor_out <= r_eor;
            r_eof_out <= r_eof;
        end
    end

    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = 32'(r_pix_out);
    assign o_end_of_row   = r_eor_out;
    assign o_end_of_frame = r_eof_out;

    `NNIR_ASSERT_NEXT(a_frame_restart, i_cmd.req && eof_now, r_col == '0 && r_row == '0 && r_xacc == '0 && r_yacc == '0)
    `NNIR_ASSERT_NEXT(a_col_step, i_cmd.req && !eor_now, r_col == COL_W'($past(r_col) + 1'b1))
    `NNIR_ASSERT_SAME(a_out_free, i_cmd.out_load, !r_out_valid || i_out_ready)

endmodule

// File: sv/nearest_neighbor_image_resize.sv
// Load word (func 0): written to the frame store at its accepting edge, one per cycle while idle,
// no result. Request word (func 1): result passes address multiply, store read and output register,
// which waits while full and not being emptied; no new word is taken before the result is loaded.
// The output register holds a result while the following load words are taken.
// Reset (synchronous, active low) clears load address, accumulators, position and output valid,
// and sets sizes to 1 and steps to 1.0; the frame store is not cleared.
module nearest_neighbor_image_resize import nnir_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [31:0]        i_pixel_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_pixel_out,
    output logic               o_end_of_row,
    output logic               o_end_of_frame,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    nnir_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nnir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    nnir_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_out_ready    (i_out_ready),
        .i_pixel_in     (i_pixel_in),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
